// ----- sv/ucx_pkg.sv -----
// ucx_pkg: shared constants, payload types and saturation helper for ui_child_transform.
// No dependencies; imported by every module of the block.
package ucx_pkg;

    // Quarter-wave sine table resolution, entries = 2^SINE_TABLE_BITS + 1
    localparam int SINE_TABLE_BITS = 10;
    localparam int TAB_N           = 1 << SINE_TABLE_BITS;
    localparam int TAB_AW          = SINE_TABLE_BITS + 1;

    // Pipeline: stages 1..5 layout, ROM read lands with stage 5, 6..8 rotation
    localparam int NUM_STAGES  = 8;
    localparam int LAYOUT_LAST = 5;
    localparam int ROT_STAGES  = NUM_STAGES - LAYOUT_LAST;

    // Local position before rounding is Q.20, after rounding Q.12
    localparam int LOC_W = 50;
    localparam int LX_W  = LOC_W - 8;

    localparam logic [15:0] QUARTER_TURN = 16'h4000;

    typedef struct packed {
        logic signed [31:0] parent_pos_x;
        logic signed [31:0] parent_pos_y;
        logic signed [31:0] parent_size_x;
        logic signed [31:0] parent_size_y;
        logic [15:0]        parent_angle;
        logic [31:0]        pos_offset_xy;
        logic [31:0]        pos_scale_xy;
        logic [31:0]        size_offset_xy;
        logic [31:0]        size_scale_xy;
        logic [31:0]        anchor_xy;
        logic [15:0]        child_angle;
        logic               visible;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_size_x;
        logic signed [31:0] out_size_y;
        logic [15:0]        out_angle;
    } t_out_item;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = $signed(v[31:0]);
        end
        return res;
    endfunction

endpackage

// ----- sv/ucx_sine_rom.sv -----
// ucx_sine_rom: quarter-wave sine ROM with registered sine and cosine read ports.
// Depends on ucx_pkg for the table size constants.
module ucx_sine_rom (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_angle,
    output logic signed [16:0] o_sin,
    output logic signed [16:0] o_cos
);
    import ucx_pkg::*;

    typedef logic [15:0] t_sine_tab [0:TAB_N];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;

    // Taylor series through x^15 in Q2.30, truncating at each step
    function automatic t_sine_tab build_tab();
        t_sine_tab       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        for (int i = 0; i <= TAB_N; i++) begin
            x    = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int k = 1; k <= 7; k++) begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if ((k & 1) != 0) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > ONE_Q30) begin
                sum = ONE_Q30;
            end
            tab[i] = 16'((sum + 64'sd16384) >>> 15);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_tab();

    // odd quadrants read the table mirrored
    function automatic logic [TAB_AW-1:0] tab_addr(input logic [15:0] a);
        logic [TAB_AW-1:0] idx;
        idx = TAB_AW'(a[13 -: SINE_TABLE_BITS]);
        return a[14] ? (TAB_AW'(TAB_N) - idx) : idx;
    endfunction

    logic [15:0]       cos_angle;
    logic [TAB_AW-1:0] sin_addr;
    logic [TAB_AW-1:0] cos_addr;
    logic [15:0]       r_sin_mag;
    logic [15:0]       r_cos_mag;
    logic              r_sin_neg;
    logic              r_cos_neg;

    assign cos_angle = i_angle + QUARTER_TURN;
    assign sin_addr  = tab_addr(i_angle);
    assign cos_addr  = tab_addr(cos_angle);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin_mag <= SINE_TAB[sin_addr];
            r_cos_mag <= SINE_TAB[cos_addr];
            r_sin_neg <= i_angle[15];
            r_cos_neg <= cos_angle[15];
        end
    end

    assign o_sin = r_sin_neg ? -$signed({1'b0, r_sin_mag}) : $signed({1'b0, r_sin_mag});
    assign o_cos = r_cos_neg ? -$signed({1'b0, r_cos_mag}) : $signed({1'b0, r_cos_mag});

endmodule

// ----- sv/ucx_layout.sv -----
// ucx_layout: pipeline stages 1..5, child size and unrotated local centre.
// Depends on ucx_pkg (t_in_item, sat32, LOC_W, LX_W).
module ucx_layout (
    input  logic                            i_clk,
    input  logic [ucx_pkg::LAYOUT_LAST:1]   i_en,
    input  ucx_pkg::t_in_item               i_item,
    output logic signed [ucx_pkg::LX_W-1:0] o_lx,
    output logic signed [ucx_pkg::LX_W-1:0] o_ly,
    output logic signed [31:0]              o_size_x,
    output logic signed [31:0]              o_size_y,
    output logic signed [31:0]              o_ppx,
    output logic signed [31:0]              o_ppy,
    output logic [15:0]                     o_angle,
    output logic [15:0]                     o_rom_angle
);
    import ucx_pkg::*;

    localparam logic signed [48:0]      RND12 = 49'sd2048;
    localparam logic signed [63:0]      RND24 = 64'sd8388608;
    localparam logic signed [16:0]      ANCHOR_HALF = 17'sd2048;
    localparam logic signed [LOC_W-1:0] RND8 = LOC_W'(128);

    // input field split
    logic signed [15:0] s0_pox, s0_poy, s0_psx, s0_psy, s0_sox, s0_soy;
    logic signed [15:0] s0_ssx, s0_ssy, s0_anx, s0_any;

    assign s0_pox = $signed(i_item.pos_offset_xy[31:16]);
    assign s0_poy = $signed(i_item.pos_offset_xy[15:0]);
    assign s0_psx = $signed(i_item.pos_scale_xy[31:16]);
    assign s0_psy = $signed(i_item.pos_scale_xy[15:0]);
    assign s0_sox = $signed(i_item.size_offset_xy[31:16]);
    assign s0_soy = $signed(i_item.size_offset_xy[15:0]);
    assign s0_ssx = $signed(i_item.size_scale_xy[31:16]);
    assign s0_ssy = $signed(i_item.size_scale_xy[15:0]);
    assign s0_anx = $signed(i_item.anchor_xy[31:16]);
    assign s0_any = $signed(i_item.anchor_xy[15:0]);

    // stage 1: scale products
    logic signed [47:0] r1_p_sx, r1_p_yy, r1_p_px, r1_p_py;
    logic signed [31:0] r1_psx, r1_psy, r1_ppx, r1_ppy;
    logic signed [15:0] r1_pox, r1_poy, r1_sox, r1_soy, r1_ssx, r1_anx, r1_any;
    logic [15:0]        r1_pang, r1_angle;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_p_sx  <= s0_ssx * i_item.parent_size_x;
            r1_p_yy  <= s0_ssy * i_item.parent_size_y;
            r1_p_px  <= s0_psx * i_item.parent_size_x;
            r1_p_py  <= s0_psy * i_item.parent_size_y;
            r1_psx   <= i_item.parent_size_x;
            r1_psy   <= i_item.parent_size_y;
            r1_ppx   <= i_item.parent_pos_x;
            r1_ppy   <= i_item.parent_pos_y;
            r1_pox   <= s0_pox;
            r1_poy   <= s0_poy;
            r1_sox   <= s0_sox;
            r1_soy   <= s0_soy;
            r1_ssx   <= s0_ssx;
            r1_anx   <= s0_anx;
            r1_any   <= s0_any;
            r1_pang  <= i_item.parent_angle;
            r1_angle <= i_item.parent_angle + i_item.child_angle;
        end
    end

    // stage 2: aspect product, size y, position base terms
    logic signed [16:0]      s1_negx;
    logic signed [48:0]      s1_yy_rnd;
    logic signed [63:0]      s1_szy_sum;
    logic signed [63:0]      r2_p_asp;
    logic signed [47:0]      r2_p_sx;
    logic signed [LOC_W-1:0] r2_base_x, r2_base_y;
    logic signed [31:0]      r2_size_y, r2_ppx, r2_ppy;
    logic signed [15:0]      r2_sox, r2_anx, r2_any;
    logic                    r2_aspect;
    logic [15:0]             r2_pang, r2_angle;

    assign s1_negx    = -(17'(r1_ssx));
    assign s1_yy_rnd  = (49'(r1_p_yy) + RND12) >>> 12;
    assign s1_szy_sum = 64'(s1_yy_rnd) + (64'(r1_soy) <<< 4);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_p_asp  <= r1_p_yy * s1_negx;
            r2_p_sx   <= r1_p_sx;
            r2_size_y <= sat32(s1_szy_sum);
            r2_base_x <= (LOC_W'(r1_pox) <<< 16) + LOC_W'(r1_p_px) - (LOC_W'(r1_psx) <<< 11);
            r2_base_y <= (LOC_W'(r1_poy) <<< 16) + LOC_W'(r1_p_py) - (LOC_W'(r1_psy) <<< 11);
            r2_ppx    <= r1_ppx;
            r2_ppy    <= r1_ppy;
            r2_sox    <= r1_sox;
            r2_anx    <= r1_anx;
            r2_any    <= r1_any;
            r2_aspect <= r1_ssx[15];
            r2_pang   <= r1_pang;
            r2_angle  <= r1_angle;
        end
    end

    // stage 3: size x, normal or aspect mode
    logic signed [63:0]      s2_asp_rnd, s2_sx_rnd, s2_szx_sum;
    logic signed [31:0]      r3_size_x, r3_size_y, r3_ppx, r3_ppy;
    logic signed [LOC_W-1:0] r3_base_x, r3_base_y;
    logic signed [15:0]      r3_anx, r3_any;
    logic [15:0]             r3_pang, r3_angle;

    assign s2_asp_rnd = (r2_p_asp + RND24) >>> 24;
    assign s2_sx_rnd  = 64'((49'(r2_p_sx) + RND12) >>> 12);
    assign s2_szx_sum = (r2_aspect ? s2_asp_rnd : s2_sx_rnd) + (64'(r2_sox) <<< 4);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_size_x <= sat32(s2_szx_sum);
            r3_size_y <= r2_size_y;
            r3_base_x <= r2_base_x;
            r3_base_y <= r2_base_y;
            r3_ppx    <= r2_ppx;
            r3_ppy    <= r2_ppy;
            r3_anx    <= r2_anx;
            r3_any    <= r2_any;
            r3_pang   <= r2_pang;
            r3_angle  <= r2_angle;
        end
    end

    // stage 4: size times (half minus anchor)
    logic signed [16:0]      s3_wx, s3_wy;
    logic signed [48:0]      r4_mx, r4_my;
    logic signed [31:0]      r4_size_x, r4_size_y, r4_ppx, r4_ppy;
    logic signed [LOC_W-1:0] r4_base_x, r4_base_y;
    logic [15:0]             r4_pang, r4_angle;

    assign s3_wx = ANCHOR_HALF - 17'(r3_anx);
    assign s3_wy = ANCHOR_HALF - 17'(r3_any);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r4_mx     <= r3_size_x * s3_wx;
            r4_my     <= r3_size_y * s3_wy;
            r4_size_x <= r3_size_x;
            r4_size_y <= r3_size_y;
            r4_base_x <= r3_base_x;
            r4_base_y <= r3_base_y;
            r4_ppx    <= r3_ppx;
            r4_ppy    <= r3_ppy;
            r4_pang   <= r3_pang;
            r4_angle  <= r3_angle;
        end
    end

    // stage 5: local centre, Q.20 rounded to Q.12
    logic signed [LOC_W-1:0] s4_lx_sum, s4_ly_sum;
    logic signed [LX_W-1:0]  r5_lx, r5_ly;
    logic signed [31:0]      r5_size_x, r5_size_y, r5_ppx, r5_ppy;
    logic [15:0]             r5_angle;

    assign s4_lx_sum = (r4_base_x + LOC_W'(r4_mx) + RND8) >>> 8;
    assign s4_ly_sum = (r4_base_y + LOC_W'(r4_my) + RND8) >>> 8;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r5_lx     <= s4_lx_sum[LX_W-1:0];
            r5_ly     <= s4_ly_sum[LX_W-1:0];
            r5_size_x <= r4_size_x;
            r5_size_y <= r4_size_y;
            r5_ppx    <= r4_ppx;
            r5_ppy    <= r4_ppy;
            r5_angle  <= r4_angle;
        end
    end

    assign o_lx        = r5_lx;
    assign o_ly        = r5_ly;
    assign o_size_x    = r5_size_x;
    assign o_size_y    = r5_size_y;
    assign o_ppx       = r5_ppx;
    assign o_ppy       = r5_ppy;
    assign o_angle     = r5_angle;
    assign o_rom_angle = r4_pang;

endmodule

// ----- sv/ucx_rotate.sv -----
// ucx_rotate: pipeline stages 6..8, rotation by the parent angle and output register.
// Depends on ucx_pkg (t_out_item, sat32, LX_W).
module ucx_rotate (
    input  logic                            i_clk,
    input  logic [ucx_pkg::ROT_STAGES:1]    i_en,
    input  logic signed [ucx_pkg::LX_W-1:0] i_lx,
    input  logic signed [ucx_pkg::LX_W-1:0] i_ly,
    input  logic signed [16:0]              i_sin,
    input  logic signed [16:0]              i_cos,
    input  logic signed [31:0]              i_size_x,
    input  logic signed [31:0]              i_size_y,
    input  logic signed [31:0]              i_ppx,
    input  logic signed [31:0]              i_ppy,
    input  logic [15:0]                     i_angle,
    output ucx_pkg::t_out_item              o_item
);
    import ucx_pkg::*;

    localparam int PROD_W = LX_W + 17;
    localparam int DIFF_W = PROD_W + 1;
    localparam int DX_W   = DIFF_W - 19;

    localparam logic signed [DIFF_W-1:0] RND19 = DIFF_W'(262144);

    // stage 6: four rotation products
    logic signed [PROD_W-1:0] r6_lxc, r6_lys, r6_lxs, r6_lyc;
    logic signed [31:0]       r6_size_x, r6_size_y, r6_ppx, r6_ppy;
    logic [15:0]              r6_angle;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r6_lxc    <= i_lx * i_cos;
            r6_lys    <= i_ly * i_sin;
            r6_lxs    <= i_lx * i_sin;
            r6_lyc    <= i_ly * i_cos;
            r6_size_x <= i_size_x;
            r6_size_y <= i_size_y;
            r6_ppx    <= i_ppx;
            r6_ppy    <= i_ppy;
            r6_angle  <= i_angle;
        end
    end

    // stage 7: combine and round Q.27 down to Q.8
    logic signed [DIFF_W-1:0] s6_dx, s6_dy;
    logic signed [DX_W-1:0]   r7_dx, r7_dy;
    logic signed [31:0]       r7_size_x, r7_size_y, r7_ppx, r7_ppy;
    logic [15:0]              r7_angle;

    assign s6_dx = (DIFF_W'(r6_lxc) - DIFF_W'(r6_lys) + RND19) >>> 19;
    assign s6_dy = (DIFF_W'(r6_lxs) + DIFF_W'(r6_lyc) + RND19) >>> 19;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r7_dx     <= s6_dx[DX_W-1:0];
            r7_dy     <= s6_dy[DX_W-1:0];
            r7_size_x <= r6_size_x;
            r7_size_y <= r6_size_y;
            r7_ppx    <= r6_ppx;
            r7_ppy    <= r6_ppy;
            r7_angle  <= r6_angle;
        end
    end

    // stage 8: add parent centre, saturate, output register
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_out.out_pos_x  <= sat32(64'(r7_ppx) + 64'(r7_dx));
            r_out.out_pos_y  <= sat32(64'(r7_ppy) + 64'(r7_dy));
            r_out.out_size_x <= r7_size_x;
            r_out.out_size_y <= r7_size_y;
            r_out.out_angle  <= r7_angle;
        end
    end

    assign o_item = r_out;

endmodule

// ----- sv/ui_child_transform.sv -----
//  channel  | direction | handshake               | payload
//  in       | input     | i_in_valid / o_in_ready | i_in_data  (ucx_pkg::t_in_item)
//  out      | output    | o_out_valid / i_out_ready | o_out_data (ucx_pkg::t_out_item)
//
// Eight register stages, one transfer per clock unless the full pipeline is stalled at
// the output. Depth comes from at most one multiply level per stage: scale products,
// aspect product, size x, anchor product, local centre with the ROM read, rotation
// products, combine, add parent centre and saturate.
// Reset clears the stage valid bits only. A stage holds while the one after it is
// full and stalled; empty stages fill behind it, so o_in_ready drops only when all
// eight are full. Invisible items are taken and dropped at entry.
module ui_child_transform (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ucx_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ucx_pkg::t_out_item o_out_data
);
    import ucx_pkg::*;

    logic [NUM_STAGES:1] r_valid;
    logic [NUM_STAGES:1] n_valid;
    logic [NUM_STAGES:1] stage_en;

    // stage k advances when empty or when stage k+1 advances
    always_comb begin
        stage_en[NUM_STAGES] = !r_valid[NUM_STAGES] || i_out_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k + 1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (stage_en[1]) begin
            n_valid[1] = i_in_valid && i_in_data.visible;
        end
        for (int k = 2; k <= NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                n_valid[k] = r_valid[k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = stage_en[1];
    assign o_out_valid = r_valid[NUM_STAGES];

    logic signed [LX_W-1:0] lx, ly;
    logic signed [31:0]     size_x, size_y, ppx, ppy;
    logic [15:0]            angle, rom_angle;
    logic signed [16:0]     sin_q15, cos_q15;

    ucx_layout u_layout (
        .i_clk       (i_clk),
        .i_en        (stage_en[LAYOUT_LAST:1]),
        .i_item      (i_in_data),
        .o_lx        (lx),
        .o_ly        (ly),
        .o_size_x    (size_x),
        .o_size_y    (size_y),
        .o_ppx       (ppx),
        .o_ppy       (ppy),
        .o_angle     (angle),
        .o_rom_angle (rom_angle)
    );

    ucx_sine_rom u_sine_rom (
        .i_clk   (i_clk),
        .i_en    (stage_en[LAYOUT_LAST]),
        .i_angle (rom_angle),
        .o_sin   (sin_q15),
        .o_cos   (cos_q15)
    );

    ucx_rotate u_rotate (
        .i_clk    (i_clk),
        .i_en     (stage_en[NUM_STAGES:LAYOUT_LAST + 1]),
        .i_lx     (lx),
        .i_ly     (ly),
        .i_sin    (sin_q15),
        .i_cos    (cos_q15),
        .i_size_x (size_x),
        .i_size_y (size_y),
        .i_ppx    (ppx),
        .i_ppy    (ppy),
        .i_angle  (angle),
        .o_item   (o_out_data)
    );

endmodule

// ----- sv/ucx_checker.sv -----
// ucx_checker: port-level assertions for ui_child_transform, attached by bind.
// Depends on ucx_pkg for the output payload type.
module ucx_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ucx_pkg::t_out_item o_out_data
);
    import ucx_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // with no result waiting nothing can hold the input back
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // a full, stalled pipeline keeps o_in_ready low until i_out_ready is high
    a_no_ready_when_blocked_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready && !o_in_ready |=> !o_in_ready || i_out_ready
            || !o_out_valid || $past(i_out_ready))
        else $error("input ready while pipeline blocked");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

endmodule

bind ui_child_transform ucx_checker u_ucx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- bench/ucx_transform_check.sv -----
`timescale 1ns / 1ps
// ucx_transform_check: watches both channels of ui_child_transform, predicts each child
// placement from the input transfer and compares it with the output transfers.
// Depends on ucx_pkg for the payload types and sine table constants.
module ucx_transform_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ucx_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ucx_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import ucx_pkg::*;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint          S32_MAX     = 64'sd2147483647;
    localparam longint          S32_MIN     = -64'sd2147483648;

    longint    sine_q15 [0:TAB_N];
    t_out_item placement_q [$];
    int        fails      = 0;
    int        result_idx = 0;

    assign o_fail_count = fails;

    // Quarter-wave table: Q2.30 Taylor series to x^15, truncating steps
    initial begin : build_sine
        longint unsigned x, x2, term;
        longint          acc;
        int              i, k;
        for (i = 0; i <= TAB_N; i++) begin
            x    = (longint'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (k = 1; k <= 7; k++) begin
                term = (term * x2) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) acc = 0;
            if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
            sine_q15[i] = (acc + (64'sd1 <<< 14)) >>> 15;
        end
    end

    function automatic longint sin_lookup(input logic [15:0] ang);
        int     idx;
        longint v;
        idx = int'(ang[13:0]) >> (14 - SINE_TABLE_BITS);
        v   = ang[14] ? sine_q15[TAB_N - idx] : sine_q15[idx];
        return ang[15] ? -v : v;
    endfunction

    function automatic longint half_s(input logic [15:0] h);
        return longint'($signed(h));
    endfunction

    // round half up, floor shift
    function automatic longint rnd_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > S32_MAX) return 32'sh7fffffff;
        if (v < S32_MIN) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_out_item place_child(input t_in_item it);
        longint      ppx, ppy, psx, psy;
        longint      po_x, po_y, ps_x, ps_y, so_x, so_y, ss_x, ss_y, an_x, an_y;
        longint      sz_x, sz_y, lx, ly, s, c;
        logic [15:0] cos_ang;
        t_out_item   r;
        ppx  = longint'(it.parent_pos_x);
        ppy  = longint'(it.parent_pos_y);
        psx  = longint'(it.parent_size_x);
        psy  = longint'(it.parent_size_y);
        po_x = half_s(it.pos_offset_xy[31:16]);
        po_y = half_s(it.pos_offset_xy[15:0]);
        ps_x = half_s(it.pos_scale_xy[31:16]);
        ps_y = half_s(it.pos_scale_xy[15:0]);
        so_x = half_s(it.size_offset_xy[31:16]);
        so_y = half_s(it.size_offset_xy[15:0]);
        ss_x = half_s(it.size_scale_xy[31:16]);
        ss_y = half_s(it.size_scale_xy[15:0]);
        an_x = half_s(it.anchor_xy[31:16]);
        an_y = half_s(it.anchor_xy[15:0]);

        // negative x scale: width follows parent height (aspect mode)
        if (ss_x < 0) begin
            sz_x = clamp32(so_x * 16 + rnd_shift(ss_y * psy * (-ss_x), 24));
        end else begin
            sz_x = clamp32(so_x * 16 + rnd_shift(ss_x * psx, 12));
        end
        sz_y = clamp32(so_y * 16 + rnd_shift(ss_y * psy, 12));

        lx = po_x * 65536 + ps_x * psx - psx * 2048 + sz_x * (2048 - an_x);
        ly = po_y * 65536 + ps_y * psy - psy * 2048 + sz_y * (2048 - an_y);
        lx = rnd_shift(lx, 8);
        ly = rnd_shift(ly, 8);

        cos_ang = it.parent_angle + QUARTER_TURN;
        s = sin_lookup(it.parent_angle);
        c = sin_lookup(cos_ang);

        r.out_pos_x  = clamp32(ppx + rnd_shift(lx * c - ly * s, 19));
        r.out_pos_y  = clamp32(ppy + rnd_shift(lx * s + ly * c, 19));
        r.out_size_x = sz_x[31:0];
        r.out_size_y = sz_y[31:0];
        r.out_angle  = it.parent_angle + it.child_angle;
        return r;
    endfunction

    task automatic report_miss(input string msg);
        $display("ERROR: %s", msg);
        fails++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_miss($sformatf("result %0d %s: got %h, want %h",
                                  result_idx, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready && i_in_data.visible) begin
                placement_q.push_back(place_child(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (placement_q.size() == 0) begin
                    report_miss($sformatf("result %0d arrived with nothing pending",
                                          result_idx));
                end else begin
                    want = placement_q.pop_front();
                    check_field("pos_x", i_out_data.out_pos_x, want.out_pos_x);
                    check_field("pos_y", i_out_data.out_pos_y, want.out_pos_y);
                    check_field("size_x", i_out_data.out_size_x, want.out_size_x);
                    check_field("size_y", i_out_data.out_size_y, want.out_size_y);
                    check_field("angle", {16'h0, i_out_data.out_angle},
                                {16'h0, want.out_angle});
                end
                result_idx++;
            end
        end
        o_pending <= placement_q.size();
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: drives ui_child_transform with directed and random child layouts under
// random stalls on both channels; ucx_transform_check does the checking.
module tb_top;
    import ucx_pkg::*;

    localparam int RUN_ITEMS   = 1530;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;
    int        fail_count;
    int        pending;
    int        cycle_cnt   = 0;
    bit        quiet       = 1'b0;

    always #5 i_clk = ~i_clk;

    ui_child_transform i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    ucx_transform_check i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_q24(input int span, input bit allow_neg);
        int v;
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: begin
                if (allow_neg) begin
                    v = int'($urandom_range(0, 2 * span)) - span;
                end else begin
                    v = int'($urandom_range(0, span));
                end
                return v;
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_half(input int span);
        int v;
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom);
            default: begin
                v = int'($urandom_range(0, 2 * span)) - span;
                return v[15:0];
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return {2'($urandom_range(0, 3)), 14'h0000};
            1: return {2'($urandom_range(0, 3)), 14'h3fff};
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.parent_pos_x   = pick_q24(1 << 24, 1'b1);
        it.parent_pos_y   = pick_q24(1 << 24, 1'b1);
        it.parent_size_x  = pick_q24(1 << 18, $urandom_range(0, 3) == 0);
        it.parent_size_y  = pick_q24(1 << 18, $urandom_range(0, 3) == 0);
        it.parent_angle   = pick_angle();
        it.pos_offset_xy  = {pick_half(4000), pick_half(4000)};
        it.pos_scale_xy   = {pick_half(6000), pick_half(6000)};
        it.size_offset_xy = {pick_half(4000), pick_half(4000)};
        it.size_scale_xy  = {pick_half(6000), pick_half(6000)};
        it.anchor_xy      = {pick_half(5000), pick_half(5000)};
        it.child_angle    = pick_angle();
        it.visible        = $urandom_range(0, 99) < 88;
        return it;
    endfunction

    // caller sits at a rising edge; returns at the edge of the transfer
    task automatic send_item(input t_in_item item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (NUM_STAGES * 2) @(posedge i_clk);
    endtask

    initial begin : sink_ready
        int n;
        @(posedge i_clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("ui_child_transform regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item base;
        t_in_item it;
        int       sent;
        int       k;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tame layout: half scales, centered anchor
        base                = '0;
        base.parent_pos_x   = 32'sd25600;
        base.parent_pos_y   = 32'sd12800;
        base.parent_size_x  = 32'sd51200;
        base.parent_size_y  = 32'sd25600;
        base.pos_scale_xy   = {16'h0800, 16'h0800};
        base.size_scale_xy  = {16'h0800, 16'h0800};
        base.anchor_xy      = {16'h0800, 16'h0800};
        base.visible        = 1'b1;

        send_item(base);
        it = rand_item();
        it.visible = 1'b0;
        send_item(it);
        it = '0;
        it.visible = 1'b1;
        send_item(it);
        it = '1;
        send_item(it);
        // centre pushed past both ends of the range
        it = base;
        it.parent_pos_x  = 32'sh7fffffff;
        it.parent_pos_y  = 32'sh7fffff00;
        it.pos_offset_xy = {16'h7fff, 16'h7fff};
        send_item(it);
        it = base;
        it.parent_pos_x  = 32'sh80000000;
        it.parent_pos_y  = 32'sh80000100;
        it.pos_offset_xy = {16'h8000, 16'h8000};
        send_item(it);
        // size saturation, then aspect mode at its extremes
        it = base;
        it.parent_size_x = 32'sh7fffffff;
        it.parent_size_y = 32'sh7fffffff;
        it.size_scale_xy = {16'h7fff, 16'h7fff};
        send_item(it);
        it = base;
        it.parent_size_x = 32'sh7fffffff;
        it.parent_size_y = 32'sh7fffffff;
        it.size_scale_xy = {16'h8000, 16'h8000};
        send_item(it);
        it = base;
        it.size_scale_xy = {16'hf000, 16'h1000};
        send_item(it);
        it = base;
        it.parent_size_x = -32'sd51200;
        it.parent_size_y = -32'sd25600;
        send_item(it);
        for (k = 0; k < 8; k++) begin
            it = base;
            it.parent_angle  = 16'(k) * 16'h2000;
            it.child_angle   = 16'hffff - 16'(k);
            it.pos_offset_xy = {16'h0640, 16'hfc00};
            send_item(it);
        end
        it = base;
        it.parent_angle  = 16'hffff;
        it.child_angle   = 16'hffff;
        it.pos_offset_xy = {16'h0640, 16'h0320};
        send_item(it);
        it = base;
        it.parent_angle = 16'h3fff;
        it.anchor_xy    = {16'h8000, 16'h7fff};
        send_item(it);
        it = base;
        it.pos_offset_xy  = {16'h7fff, 16'h8000};
        it.size_offset_xy = {16'h8000, 16'h7fff};
        it.pos_scale_xy   = {16'h8000, 16'h7fff};
        send_item(it);
        it = '0;
        it.parent_pos_x   = 32'sh80000000;
        it.parent_pos_y   = 32'sh80000000;
        it.parent_size_x  = 32'sh80000000;
        it.parent_size_y  = 32'sh80000000;
        it.pos_offset_xy  = 32'h80008000;
        it.pos_scale_xy   = 32'h80008000;
        it.size_offset_xy = 32'h80008000;
        it.size_scale_xy  = 32'h80008000;
        it.anchor_xy      = 32'h80008000;
        it.visible        = 1'b1;
        send_item(it);

        wait_drained();

        sent = 0;
        while (sent < RUN_ITEMS) begin
            quiet = ((sent / 120) % 5) == 4;
            it = rand_item();
            send_item(it);
            sent++;
            if (sent == RUN_ITEMS / 2) wait_drained();
        end
        quiet = 1'b0;
        wait_drained();

        if (fail_count == 0) begin
            $display("ui_child_transform regression: pass");
        end else begin
            $display("ui_child_transform regression: fail");
        end
        $finish;
    end

endmodule
